// ===== hdl/pcvc_pkg.sv =====
// shared constants, codes and types of the pileup counter and variant caller
package pcvc_pkg;

	localparam int POSITIONS_DEF  = 4096;
	localparam int COUNT_BITS_DEF = 24;

	localparam int POS_W      = 12;
	localparam int BASE_W     = 3;
	localparam int DEPTH_W    = 26;
	localparam int FREQ_W     = 16;
	localparam int MINC_W     = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int NUM_BASES  = 4;

	localparam logic ACT_COUNT = 1'b0;
	localparam logic ACT_CALL  = 1'b1;

	localparam logic [BASE_W-1:0] BASE_A  = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C  = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G  = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T  = 3'd3;
	localparam logic [BASE_W-1:0] NO_BASE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_REF_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_FIX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_CUT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 2'd3;

	localparam logic [FREQ_W-1:0]  FREQ_CUT_RST = 16'd3277;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX    = 26'h3FFFFFF;

	typedef struct packed {
		logic              ref_mode;
		logic              allow_fix;
		logic [FREQ_W-1:0] freq_cut;
		logic [MINC_W-1:0] min_count;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [POS_W-1:0]  pos;
		logic [BASE_W-1:0] ref_base;
	} call_ctl_t;

endpackage

// ===== hdl/pileup_count_and_variant_call.sv =====
// top level of the pileup counter and variant caller
//
// input stream s_*: one transfer per item; tuser[0] selects count (0) or call (1),
// tdata carries position, aligned base and reference base. count transfers
// add one base to the A/C/G/T counters of a position and give no result; call
// transfers give one result on m_* with position, consensus, depth and the
// called alternate bases.
// config channel cfg_*: always ready; index 0 reference mode, 1 allow fixation,
// 2 frequency cut (Q16), 3 minimum count. write only while the block is idle.
// throughput: one item per cycle while s_tready is high (no clearing pass and no
// stall), set by the single read-modify-write of the count ram with forwarding of the previous item's write.
// a call result passes the ram read, depth and consensus, threshold products and
// the compare into the output register, from which it is presented on m_*.
// reset: the count ram is swept to zero, one entry per cycle, over all POSITIONS
// entries; s_tready stays low during the sweep.
// stall: a result waits in the output register; new items keep being taken
// until a second call result reaches the last stage, then s_tready drops.
module pileup_count_and_variant_call
	import pcvc_pkg::*;
#(
	parameter int POSITIONS  = POSITIONS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // position, base, ref_base, zero pad
	input  logic [0:0]            s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // call_position, consensus, depth, alt_called, pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg_q;
	call_ctl_t call_ctl;
	logic      stall;

	logic [NUM_BASES*COUNT_BITS-1:0] counts;
	logic [POS_W-1:0]                call_position;
	logic [BASE_W-1:0]               consensus;
	logic [DEPTH_W-1:0]              depth;
	logic [NUM_BASES-1:0]            alt_called;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_mode  <= 1'b0;
			cfg_q.allow_fix <= 1'b0;
			cfg_q.freq_cut  <= FREQ_CUT_RST;
			cfg_q.min_count <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_REF_MODE:  cfg_q.ref_mode  <= cfg_data[0];
				REG_ALLOW_FIX: cfg_q.allow_fix <= cfg_data[0];
				REG_FREQ_CUT:  cfg_q.freq_cut  <= cfg_data[FREQ_W-1:0];
				REG_MIN_COUNT: cfg_q.min_count <= cfg_data[MINC_W-1:0];
				default: ;
			endcase
		end
	end

	pcvc_counter #(
		.POSITIONS  (POSITIONS),
		.COUNT_BITS (COUNT_BITS)
	) u_counter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.action   (s_tuser[0]),
		.position (s_tdata[11:0]),
		.base     (s_tdata[14:12]),
		.ref_base (s_tdata[17:15]),
		.stall    (stall),
		.call_o   (call_ctl),
		.counts_o (counts)
	);

	pcvc_caller #(
		.COUNT_BITS (COUNT_BITS)
	) u_caller (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.call_i        (call_ctl),
		.counts_i      (counts),
		.stall         (stall),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.call_position (call_position),
		.consensus     (consensus),
		.depth         (depth),
		.alt_called    (alt_called)
	);

	assign m_tdata = {3'b000, alt_called, depth, consensus, call_position};

endmodule

// ===== hdl/pcvc_ram.sv =====
// generic simple dual-port ram with registered read
module pcvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/pcvc_counter.sv =====
// count store: clearing pass, read-modify-write of base counters, forwarding
module pcvc_counter
	import pcvc_pkg::*;
#(
	parameter int POSITIONS  = POSITIONS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  logic [POS_W-1:0]                position,
	input  logic [BASE_W-1:0]               base,
	input  logic [BASE_W-1:0]               ref_base,
	input  logic                            stall,
	output call_ctl_t                       call_o,
	output logic [NUM_BASES*COUNT_BITS-1:0] counts_o
);

	localparam int AW = $clog2(POSITIONS);
	localparam int WW = NUM_BASES * COUNT_BITS;

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic              valid_s1;
	logic              action_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [BASE_W-1:0] base_s1;
	logic [BASE_W-1:0] rb_s1;
	logic              in_range_s1;
	logic [AW-1:0]     addr_s1;

	logic          fwd_valid_q;
	logic [AW-1:0] fwd_addr_q;
	logic [WW-1:0] fwd_data_q;

	logic          accept;
	logic          in_range;
	logic [AW-1:0] raddr;
	logic [WW-1:0] rdata;
	logic [WW-1:0] cur;
	logic [WW-1:0] nxt;
	logic          wen_s1;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;

	assign in_ready = !clr_busy_q && !stall;
	assign accept   = in_valid && in_ready;
	assign in_range = 32'(position) < 32'(POSITIONS);
	assign raddr    = AW'(position);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(POSITIONS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (!stall) begin
			valid_s1    <= accept;
			fwd_valid_q <= wen_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action;
			pos_s1      <= position;
			base_s1     <= base;
			rb_s1       <= ref_base;
			in_range_s1 <= in_range;
			addr_s1     <= raddr;
		end
		if (!stall && wen_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= nxt;
		end
	end

	// the write of the previous item lands on the same edge as this read
	assign cur = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata;

	always_comb begin
		nxt = cur;
		for (int b = 0; b < NUM_BASES; b++) begin
			if (base_s1 == BASE_W'(b) &&
			    cur[b*COUNT_BITS +: COUNT_BITS] != {COUNT_BITS{1'b1}}) begin
				nxt[b*COUNT_BITS +: COUNT_BITS] = cur[b*COUNT_BITS +: COUNT_BITS] + 1'b1;
			end
		end
	end

	assign wen_s1 = valid_s1 && !stall && action_s1 == ACT_COUNT && in_range_s1 &&
	                base_s1 != NO_BASE && !base_s1[2];

	assign ram_we    = clr_busy_q || wen_s1;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_busy_q ? '0 : nxt;

	pcvc_ram #(
		.WIDTH(WW),
		.DEPTH(POSITIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign call_o.valid    = valid_s1 && action_s1 == ACT_CALL;
	assign call_o.pos      = pos_s1;
	assign call_o.ref_base = rb_s1;
	assign counts_o        = in_range_s1 ? cur : '0;

`ifndef SYNTH
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("clearing pass restarted");
	a_no_count_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wen_s1 |-> !clr_busy_q)
		else $error("count write during clearing pass");
`endif

endmodule

// ===== hdl/pcvc_caller.sv =====
// variant call pipeline: depth and consensus, threshold products, compares, output
module pcvc_caller
	import pcvc_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cfg_t                            cfg,
	input  call_ctl_t                       call_i,
	input  logic [NUM_BASES*COUNT_BITS-1:0] counts_i,
	output logic                            stall,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [POS_W-1:0]                call_position,
	output logic [BASE_W-1:0]               consensus,
	output logic [DEPTH_W-1:0]              depth,
	output logic [NUM_BASES-1:0]            alt_called
);

	localparam int NW = COUNT_BITS + 2;
	localparam int PW = NW + FREQ_W + 1;
	localparam int MW = (COUNT_BITS > MINC_W) ? COUNT_BITS : MINC_W;

	logic                  valid_s2, valid_s3, valid_s4;
	logic [POS_W-1:0]      pos_s2, pos_s3, pos_s4;
	logic [BASE_W-1:0]     rb_s2;
	logic [COUNT_BITS-1:0] c_s2 [NUM_BASES];
	logic [COUNT_BITS-1:0] c_s3 [NUM_BASES];
	logic [COUNT_BITS-1:0] c_s4 [NUM_BASES];
	logic [NW-1:0]         n_s3, n_s4;
	logic [BASE_W-1:0]     cons_s3, cons_s4;
	logic [PW-1:0]         lo_s4, hi_s4;

	logic                 out_valid_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [BASE_W-1:0]    out_cons_q;
	logic [DEPTH_W-1:0]   out_depth_q;
	logic [NUM_BASES-1:0] out_alt_q;

	logic [NW-1:0]        n_sum;
	logic [1:0]           maj;
	logic [BASE_W-1:0]    cons_nxt;
	logic                 no_upper;
	logic [PW-1:0]        scaled;
	logic [NUM_BASES-1:0] alt_nxt;
	logic [DEPTH_W-1:0]   depth_nxt;

	assign stall = out_valid_q && !out_ready && valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= call_i.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		n_sum = '0;
		for (int b = 0; b < NUM_BASES; b++) begin
			n_sum = n_sum + NW'(c_s2[b]);
		end
		maj = 2'd0;
		for (int b = 1; b < NUM_BASES; b++) begin
			if (c_s2[b] > c_s2[maj]) begin
				maj = 2'(b);
			end
		end
		if (cfg.ref_mode) begin
			cons_nxt = (rb_s2 < NO_BASE) ? rb_s2 : NO_BASE;
		end else if (n_sum == '0) begin
			cons_nxt = NO_BASE;
		end else begin
			cons_nxt = BASE_W'(maj);
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			pos_s2 <= call_i.pos;
			rb_s2  <= call_i.ref_base;
			for (int b = 0; b < NUM_BASES; b++) begin
				c_s2[b] <= counts_i[b*COUNT_BITS +: COUNT_BITS];
			end
			pos_s3  <= pos_s2;
			c_s3    <= c_s2;
			n_s3    <= n_sum;
			cons_s3 <= cons_nxt;
			pos_s4  <= pos_s3;
			c_s4    <= c_s3;
			n_s4    <= n_s3;
			cons_s4 <= cons_s3;
			lo_s4   <= PW'(cfg.freq_cut) * PW'(n_s3);
			hi_s4   <= (PW'(1 << FREQ_W) - PW'(cfg.freq_cut)) * PW'(n_s3);
		end
	end

	assign no_upper = cfg.ref_mode && cfg.allow_fix;

	always_comb begin
		alt_nxt = '0;
		scaled  = '0;
		for (int b = 0; b < NUM_BASES; b++) begin
			scaled = PW'(c_s4[b]) << FREQ_W;
			if (cons_s4 != NO_BASE && cons_s4 != BASE_W'(b) && scaled > lo_s4 &&
			    (no_upper || scaled < hi_s4) &&
			    MW'(c_s4[b]) >= MW'(cfg.min_count)) begin
				alt_nxt[b] = 1'b1;
			end
		end
		depth_nxt = (64'(n_s4) > 64'(DEPTH_MAX)) ? DEPTH_MAX : DEPTH_W'(n_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s4 && !stall) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s4 && !stall) begin
			out_pos_q   <= pos_s4;
			out_cons_q  <= cons_s4;
			out_depth_q <= depth_nxt;
			out_alt_q   <= alt_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign call_position = out_pos_q;
	assign consensus     = out_cons_q;
	assign depth         = out_depth_q;
	assign alt_called    = out_alt_q;

`ifndef SYNTH
	a_cons_not_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_cons_q != NO_BASE && !out_cons_q[2] |->
		out_alt_q[out_cons_q[1:0]] == 1'b0)
		else $error("consensus base marked as alternate");
	a_no_cons_no_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_cons_q == NO_BASE |-> out_alt_q == '0)
		else $error("alternate called without consensus");
`endif

endmodule

// ===== tb/sv/pileup_count_and_variant_call_test.sv =====
// self-checking stream testbench for the pileup counter and variant caller
module pileup_count_and_variant_call_test;
	import pcvc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_BITS   = COUNT_BITS_DEF;
	localparam int STALL_LIMIT  = 20000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 8;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 205;

	typedef struct packed {
		logic              action;
		logic [POS_W-1:0]  position;
		logic [BASE_W-1:0] base;
		logic [BASE_W-1:0] ref_base;
	} pile_item_t;

	typedef struct packed {
		logic [POS_W-1:0]     position;
		logic [BASE_W-1:0]    consensus;
		logic [DEPTH_W-1:0]   depth;
		logic [NUM_BASES-1:0] alts;
	} call_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata   = '0;   // position, base, ref_base, zero pad
	logic [0:0]            s_tuser   = '0;   // action
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [47:0]           m_tdata;          // call_position, consensus, depth, alt_called, pad
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	pileup_count_and_variant_call uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [COUNT_BITS-1:0] tally [NUM_BASES][POSITIONS_DEF] = '{default: '0};
	logic                  mode_ref = 1'b0;
	logic                  mode_fix = 1'b0;
	logic [FREQ_W-1:0]     cut      = FREQ_CUT_RST;
	logic [MINC_W-1:0]     min_cnt  = '0;

	pile_item_t pending_items[$];
	call_t      calls_expected[$];
	pile_item_t offered;
	logic [POS_W-1:0] hot_pos [16];

	bit s_done;
	bit quiet;
	bit hold_request;
	int send_gap;
	int stall_left;
	int hold_left;
	int idle_cycles;
	int errors;
	int n_counts;
	int n_calls;
	int n_checked;

	always #10 clk = ~clk;

	function automatic call_t call_at(input logic [POS_W-1:0] pos, input logic [BASE_W-1:0] rb);
		call_t             r;
		longint unsigned   c [NUM_BASES];
		longint unsigned   n;
		longint unsigned   scaled;
		logic [BASE_W-1:0] cons;
		logic              no_upper;
		n = 0;
		for (int b = 0; b < NUM_BASES; b++) begin
			c[b] = tally[b][pos];
			n += c[b];
		end
		if (mode_ref) begin
			cons = (rb < NO_BASE) ? rb : NO_BASE;
		end else if (n == 0) begin
			cons = NO_BASE;
		end else begin
			cons = BASE_A;
			for (int b = 1; b < NUM_BASES; b++)
				if (c[b] > c[cons])
					cons = BASE_W'(b);
		end
		no_upper = mode_ref && mode_fix;
		r.alts = '0;
		if (cons != NO_BASE) begin
			for (int b = 0; b < NUM_BASES; b++) begin
				scaled = c[b] << 16;
				if (b != int'(cons) && scaled > longint'(cut) * n
						&& (no_upper || scaled < (65536 - longint'(cut)) * n)
						&& c[b] >= longint'(min_cnt))
					r.alts[b] = 1'b1;
			end
		end
		r.position  = pos;
		r.consensus = cons;
		r.depth     = (n > DEPTH_MAX) ? DEPTH_MAX : DEPTH_W'(n);
		return r;
	endfunction

	task automatic check_field(input string what, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_done) begin
			if (send_gap != 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 14);
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				offered = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {6'd0, offered.ref_base, offered.base, offered.position};
				s_tuser  <= offered.action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		s_done = 1'b0;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// prediction, checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (s_tvalid && s_tready) begin
				s_done      = 1'b1;
				idle_cycles = 0;
				if (offered.action == ACT_COUNT) begin
					n_counts++;
					if (offered.base < NO_BASE && tally[offered.base][offered.position] != '1)
						tally[offered.base][offered.position] += 1'b1;
				end else begin
					n_calls++;
					calls_expected = {calls_expected,
						call_at(offered.position, offered.ref_base)};
				end
			end
			if (m_tvalid && m_tready) begin
				call_t want;
				idle_cycles = 0;
				if (calls_expected.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected call result %h", $time, m_tdata);
				end else begin
					want = calls_expected.pop_front();
					n_checked++;
					check_field("call_position", want.position, m_tdata[11:0]);
					check_field("consensus", want.consensus, m_tdata[14:12]);
					check_field("depth", want.depth, m_tdata[40:15]);
					check_field("alt_called", want.alts, m_tdata[44:41]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
				case (cfg_index)
					REG_REF_MODE:  mode_ref = cfg_data[0];
					REG_ALLOW_FIX: mode_fix = cfg_data[0];
					REG_FREQ_CUT:  cut      = cfg_data[FREQ_W-1:0];
					REG_MIN_COUNT: min_cnt  = cfg_data[MINC_W-1:0];
					default: ;
				endcase
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d results still outstanding", calls_expected.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic push_item(input logic act, input int pos, input int b, input int rb);
		pile_item_t it;
		it.action   = act;
		it.position = POS_W'(pos);
		it.base     = BASE_W'(b);
		it.ref_base = BASE_W'(rb);
		pending_items = {pending_items, it};
	endtask

	// pileups at hot positions with a dominant base, each closed by a call; some noise
	task automatic queue_random(input int budget);
		int added;
		int run_len;
		int dom;
		int total;
		int r;
		int b;
		int rb;
		int pos;
		int w [NUM_BASES];
		added = 0;
		while (added < budget) begin
			if ($urandom_range(0, 9) < 8) begin
				pos     = hot_pos[$urandom_range(0, 15)];
				run_len = $urandom_range(1, 30);
				dom     = $urandom_range(0, 3);
				total   = 0;
				for (int k = 0; k < NUM_BASES; k++) begin
					w[k]   = (k == dom) ? 16 : $urandom_range(0, 6);
					total += w[k];
				end
				repeat (run_len) begin
					if ($urandom_range(0, 15) == 0) begin
						push_item(ACT_COUNT, pos, $urandom_range(4, 7), $urandom_range(0, 7));
					end else begin
						r = $urandom_range(0, total - 1);
						b = 0;
						while (r >= w[b]) begin
							r -= w[b];
							b++;
						end
						push_item(ACT_COUNT, pos, b, $urandom_range(0, 7));
						added++;
					end
				end
				rb = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
				push_item(ACT_CALL, pos, $urandom_range(0, 7), rb);
				added++;
			end else begin
				b = $urandom_range(0, 7);
				r = $urandom_range(0, 1);
				push_item(r[0], $urandom_range(0, 4095), b, $urandom_range(0, 7));
				if (r[0] == ACT_CALL || b < NO_BASE)
					added++;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || calls_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input int rm, input int fx, input int fc, input int mc);
		write_reg(REG_REF_MODE, rm);
		write_reg(REG_ALLOW_FIX, fx);
		write_reg(REG_FREQ_CUT, fc);
		write_reg(REG_MIN_COUNT, mc);
	endtask

	initial begin
		hot_pos[0] = '0;
		hot_pos[1] = '1;
		for (int k = 2; k < 16; k++)
			hot_pos[k] = POS_W'($urandom_range(0, 4095));
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!s_tready);

		// reset values of the registers: zero depth, majority, tie, ignored symbols
		push_item(ACT_CALL, 0, 0, 7);
		push_item(ACT_COUNT, 4095, BASE_A, 0);
		push_item(ACT_COUNT, 4095, BASE_C, 0);
		push_item(ACT_COUNT, 4095, BASE_C, 0);
		push_item(ACT_COUNT, 4095, BASE_G, 0);
		push_item(ACT_COUNT, 4095, BASE_T, 0);
		push_item(ACT_COUNT, 4095, 4, 0);
		push_item(ACT_COUNT, 4095, 7, 0);
		push_item(ACT_CALL, 4095, 0, 0);
		push_item(ACT_COUNT, 0, BASE_G, 3);
		push_item(ACT_COUNT, 0, BASE_T, 3);
		push_item(ACT_CALL, 0, 7, 3);
		push_item(ACT_COUNT, 12'hAAA, BASE_A, 5);
		push_item(ACT_CALL, 12'hAAA, 2, 0);
		push_item(ACT_COUNT, 12'h555, BASE_T, 6);
		push_item(ACT_COUNT, 12'h555, BASE_T, 6);
		push_item(ACT_COUNT, 12'h555, 6, 6);
		push_item(ACT_CALL, 12'h555, 5, 4);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				0: set_regs(0, 0, 3277, 0);
				1: set_regs(0, 1, 0, 0);
				2: set_regs(1, 0, 16384, 1);
				3: set_regs(1, 1, 32768, 2);
				4: set_regs(1, 1, 0, 16777215);
				5: set_regs(0, 0, 32768, 3);
				6: set_regs(1, 0, $urandom_range(0, 32768), $urandom_range(0, 4));
				default: set_regs(0, $urandom_range(0, 1), 21845, 0);
			endcase
			if (phase == PHASES - 1)
				quiet = 1'b1;
			queue_random(PHASE_ITEMS);
			if (phase == 2)
				hold_request = 1'b1;
		end
		drain();

		$display("covered %0d count and %0d call transfers, %0d call results checked",
			n_counts, n_calls, n_checked);
		$display("register settings: both consensus modes, fixation on and off, cut 0 to 0.5");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pcvc_pkg.sv
hdl/pcvc_ram.sv
hdl/pcvc_counter.sv
hdl/pcvc_caller.sv
hdl/pileup_count_and_variant_call.sv
tb/sv/pileup_count_and_variant_call_test.sv
